FILE: sv/ooktx_pkg.sv
// Shared types and constants for the OOK remote frame transmitter.
// No dependencies; used by the top level and the frame builder.

package ooktx_pkg;

  localparam int FRAME_LEN = 40;

  localparam logic [7:0] HDR_CH_ONE   = 8'h80;
  localparam logic [7:0] HDR_CH_TWO   = 8'hF0;
  localparam logic [7:0] TRL_CH_ONE   = 8'h0E;
  localparam logic [7:0] PWR_MOD      = 8'd101;
  localparam logic [7:0] PWR_MOD_X2   = 8'd202;

  // command codes
  localparam logic [1:0] CMD_SHOCK = 2'd0;
  localparam logic [1:0] CMD_BUZZ  = 2'd1;
  localparam logic [1:0] CMD_BEEP  = 2'd2;
  localparam logic [1:0] CMD_LIGHT = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_BIT_TICKS  = 3'd0;
  localparam logic [2:0] REG_DELIM      = 3'd1;
  localparam logic [2:0] REG_PRE_HIGH   = 3'd2;
  localparam logic [2:0] REG_PRE_LOW    = 3'd3;
  localparam logic [2:0] REG_REPEAT     = 3'd4;

  // input word payload, lowest field in the lowest bits
  typedef struct packed {
    logic [7:0] id_low;
    logic [7:0] id_high;
    logic [7:0] power;
    logic [1:0] command;
    logic       channel;
  } in_word_t;

  typedef logic [FRAME_LEN-1:0] frame_t;

  function automatic logic [7:0] trail_code(input logic [1:0] cmd);
    logic [7:0] code;
    case (cmd)
      CMD_SHOCK: code = 8'h70;
      CMD_BUZZ:  code = 8'hB0;
      CMD_BEEP:  code = 8'hD0;
      CMD_LIGHT: code = 8'hE0;
      default:   code = 8'h70;
    endcase
    return code;
  endfunction

endpackage

FILE: sv/ooktx_frame_build.sv
// Frame builder: packs header, ID bytes, power mod 101 and trailer.
// Depends on ooktx_pkg.

module ooktx_frame_build (
  input  ooktx_pkg::in_word_t word_i,
  output ooktx_pkg::frame_t   frame_o
);

  logic [7:0] pwr_mod;
  logic [7:0] hdr;
  logic [7:0] trl;

  // power < 256, so at most two subtractions of 101
  always_comb begin
    if (word_i.power >= ooktx_pkg::PWR_MOD_X2) begin
      pwr_mod = word_i.power - ooktx_pkg::PWR_MOD_X2;
    end else if (word_i.power >= ooktx_pkg::PWR_MOD) begin
      pwr_mod = word_i.power - ooktx_pkg::PWR_MOD;
    end else begin
      pwr_mod = word_i.power;
    end
  end

  assign hdr = (word_i.channel ? ooktx_pkg::HDR_CH_TWO : ooktx_pkg::HDR_CH_ONE)
             + (8'd1 << word_i.command);
  assign trl = ooktx_pkg::trail_code(word_i.command)
             | (word_i.channel ? 8'h00 : ooktx_pkg::TRL_CH_ONE);

  assign frame_o = {hdr, word_i.id_high, word_i.id_low, pwr_mod, trl};

endmodule

FILE: sv/ook_remote_frame_transmitter.sv
// Top level of the OOK remote frame transmitter: phase sequencer, timer,
// config registers and output register. Depends on ooktx_pkg, ooktx_frame_build.
//
// Usage:
//  - Input stream (in_*): each word is a send (in_tuser=1) or a tick (in_tuser=0).
//    A send latches a 40-bit frame and starts a burst; a send while busy is
//    rejected. Each tick advances the line by one tick and reports its level.
//  - Output stream (out_*): exactly one word per input word, in order.
//    out_tlast flags the last tick of the last packet of a burst.
//  - Config port (cfg_*): single-cycle writes of phase lengths and repeat
//    count; write only while no burst is running.
//  - Output valid in the cycle after input accept. Throughput: one word per
//    cycle while out_tready is high, set by the single register stage holding
//    the result; phase timer compare and bit select fit between input and result.
//  - Receiver stall: the output register holds its word; in_tready stays high
//    only while the output register is empty or being drained in the same
//    cycle, so a stall reaches in_tready combinationally with nothing lost.
//  - Reset (rst_n low, synchronous): config returns to its defaults, the
//    sequencer goes idle with the line low and the output register empties.

module ook_remote_frame_transmitter #(
  parameter int TIMER_BITS = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // channel, command[1:0], power[7:0], id_high, id_low
  input  logic        in_tuser,  // req_type: 0 tick, 1 send
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata, // line_level, busy_res, rejected, zero pad
  output logic        out_tlast, // burst_done
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = (TIMER_BITS > 17) ? TIMER_BITS : 17;
  localparam logic [CW-1:0] TMAX_CW = CW'((64'd1 << TIMER_BITS) - 64'd1);

  // sequencer phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_PRE_HIGH = 3'd1;
  localparam logic [2:0] PH_PRE_LOW  = 3'd2;
  localparam logic [2:0] PH_DLM_LOW  = 3'd3;
  localparam logic [2:0] PH_DLM_HIGH = 3'd4;
  localparam logic [2:0] PH_BIT      = 3'd5;
  localparam logic [2:0] PH_TRAIL    = 3'd6;

  localparam logic [5:0] FRAME_LEN6 = 6'(ooktx_pkg::FRAME_LEN);
  localparam logic [5:0] LAST_BIT6  = 6'(ooktx_pkg::FRAME_LEN - 1);

  // config registers
  logic [15:0] bit_ticks_r, delim_ticks_r, pre_high_r, pre_low_r;
  logic [3:0]  repeat_r;

  // sequencer state
  logic                  active_r, active_nxt;
  ooktx_pkg::frame_t     frame_r, frame_nxt;
  logic [5:0]            bit_idx_r, bit_idx_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [3:0]            rep_r, rep_nxt;

  // output register
  logic       out_valid_r;
  logic [2:0] out_data_r, out_data_nxt; // line, busy, rejected
  logic       out_last_r, out_last_nxt;

  ooktx_pkg::in_word_t in_word;
  ooktx_pkg::frame_t   new_frame;
  logic                in_acc;

  logic [15:0]           bit_nz;
  logic [CW-1:0]         len_raw;
  logic [TIMER_BITS-1:0] len_fit;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [5:0]            bit_sel;
  logic                  level;

  assign in_word   = ooktx_pkg::in_word_t'(in_tdata[26:0]);
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  ooktx_frame_build u_frame (
    .word_i  (in_word),
    .frame_o (new_frame)
  );

  // current phase length, zero taken as one and clamped to the timer range
  assign bit_nz = (bit_ticks_r == 16'd0) ? 16'd1 : bit_ticks_r;

  always_comb begin
    case (phase_r)
      PH_PRE_HIGH: len_raw = CW'(pre_high_r);
      PH_PRE_LOW:  len_raw = CW'(pre_low_r);
      PH_DLM_LOW,
      PH_DLM_HIGH: len_raw = CW'(delim_ticks_r);
      PH_BIT:      len_raw = CW'(bit_ticks_r);
      PH_TRAIL:    len_raw = CW'({bit_nz, 1'b0});
      default:     len_raw = CW'(1);
    endcase
  end

  always_comb begin
    if (len_raw == '0) begin
      len_fit = TIMER_BITS'(1);
    end else if (len_raw > TMAX_CW) begin
      len_fit = TMAX_CW[TIMER_BITS-1:0];
    end else begin
      len_fit = len_raw[TIMER_BITS-1:0];
    end
  end

  assign timer_inc = timer_r + TIMER_BITS'(1);

  // line level of the current phase; bits go out MSB first
  assign bit_sel = LAST_BIT6 - bit_idx_r;

  always_comb begin
    case (phase_r)
      PH_PRE_HIGH,
      PH_DLM_HIGH: level = 1'b1;
      PH_BIT:      level = (bit_idx_r < FRAME_LEN6) ? frame_r[bit_sel] : 1'b0;
      default:     level = 1'b0;
    endcase
  end

  always_comb begin
    active_nxt   = active_r;
    frame_nxt    = frame_r;
    bit_idx_nxt  = bit_idx_r;
    phase_nxt    = phase_r;
    timer_nxt    = timer_r;
    rep_nxt      = rep_r;
    out_data_nxt = 3'b000;
    out_last_nxt = 1'b0;

    if (in_tuser) begin
      if (active_r) begin
        out_data_nxt[2] = 1'b1;                    // rejected
      end else begin
        active_nxt  = 1'b1;
        frame_nxt   = new_frame;
        phase_nxt   = PH_PRE_HIGH;
        timer_nxt   = '0;
        bit_idx_nxt = '0;
        rep_nxt     = (repeat_r == 4'd0) ? 4'd1 : repeat_r;
      end
    end else if (active_r) begin
      out_data_nxt[0] = level;
      timer_nxt       = timer_inc;
      if (timer_inc >= len_fit) begin
        timer_nxt = '0;
        case (phase_r)
          PH_PRE_HIGH: phase_nxt = PH_PRE_LOW;
          PH_PRE_LOW:  phase_nxt = PH_DLM_LOW;
          PH_DLM_LOW:  phase_nxt = PH_DLM_HIGH;
          PH_DLM_HIGH: phase_nxt = (bit_idx_r < FRAME_LEN6) ? PH_BIT : PH_TRAIL;
          PH_BIT: begin
            bit_idx_nxt = bit_idx_r + 6'd1;
            phase_nxt   = PH_DLM_LOW;
          end
          PH_TRAIL: begin
            rep_nxt     = rep_r - 4'd1;
            bit_idx_nxt = '0;
            if (rep_r == 4'd1) begin
              active_nxt   = 1'b0;
              phase_nxt    = PH_IDLE;
              out_last_nxt = 1'b1;
            end else begin
              phase_nxt = PH_PRE_HIGH;
            end
          end
          default: begin
            active_nxt = 1'b0;
            phase_nxt  = PH_IDLE;
          end
        endcase
      end
    end
    out_data_nxt[1] = active_nxt;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r   <= 16'd640;
      delim_ticks_r <= 16'd190;
      pre_high_r    <= 16'd1500;
      pre_low_r     <= 16'd750;
      repeat_r      <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        ooktx_pkg::REG_BIT_TICKS: bit_ticks_r   <= cfg_wdata;
        ooktx_pkg::REG_DELIM:     delim_ticks_r <= cfg_wdata;
        ooktx_pkg::REG_PRE_HIGH:  pre_high_r    <= cfg_wdata;
        ooktx_pkg::REG_PRE_LOW:   pre_low_r     <= cfg_wdata;
        ooktx_pkg::REG_REPEAT:    repeat_r      <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      frame_r   <= '0;
      bit_idx_r <= '0;
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      rep_r     <= '0;
    end else if (in_acc) begin
      active_r  <= active_nxt;
      frame_r   <= frame_nxt;
      bit_idx_r <= bit_idx_nxt;
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      rep_r     <= rep_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

FILE: sv/ooktx_checker.sv
// Port-level checker for the OOK remote frame transmitter, bound to the top.
// Depends on ook_remote_frame_transmitter ports only.

module ooktx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // the line is only driven high inside a burst
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("line high while not busy");

  // a rejected send leaves the running burst in place
  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && !out_tlast)
    else $error("rejected word without busy");

  // burst end drops busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[1] && !out_tdata[0])
    else $error("burst done while still busy");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind ook_remote_frame_transmitter ooktx_checker u_ooktx_checker (.*);

FILE: tb/ook_remote_frame_transmitter_tb.sv
// Self-checking testbench for ook_remote_frame_transmitter: directed and random
// send/tick streams checked word by word against a line-level predictor.
// Depends on ooktx_pkg and the transmitter RTL.

module ook_remote_frame_transmitter_tb;

  localparam int TIMER_BITS     = 17;
  localparam int TIMER_MAX      = (1 << TIMER_BITS) - 1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_HOLD_LEN    = 300;
  localparam int RANDOM_WORDS   = 40;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_SEND = 1'b1;

  // powers around the modulo-101 wrap, four bytes packed low first
  localparam logic [31:0] EDGE_POWER = {8'd255, 8'd202, 8'd101, 8'd100};

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE_HIGH, PH_PRE_LOW, PH_DLM_LOW, PH_DLM_HIGH, PH_BIT, PH_TRAIL
  } line_phase_t;

  // one expected output word
  typedef struct packed {
    logic line;
    logic busy;
    logic done;
    logic rej;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // channel, command[1:0], power[7:0], id_high, id_low
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // line_level, busy_res, rejected, zero pad
  logic        out_tlast;       // burst_done
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  ook_remote_frame_transmitter #(.TIMER_BITS(TIMER_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8-unit clock, rising edges at 4, 12, 20 ...
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Line predictor: its own copy of the registers and sequencer state.
  // Updated once per accepted input word, in accept order.
  // ---------------------------------------------------------------------
  logic [15:0]           reg_bit_ticks  = 16'd640;
  logic [15:0]           reg_delim      = 16'd190;
  logic [15:0]           reg_pre_high   = 16'd1500;
  logic [15:0]           reg_pre_low    = 16'd750;
  logic [3:0]            reg_repeat     = 4'd8;

  logic                  pred_active    = 1'b0;
  ooktx_pkg::frame_t     pred_frame     = '0;
  logic [5:0]            pred_bit_idx   = '0;
  line_phase_t           pred_phase     = PH_IDLE;
  logic [TIMER_BITS-1:0] pred_timer     = '0;
  logic [3:0]            pred_reps_left = '0;

  line_result_t          expected_q[$];
  int                    errors  = 0;
  int                    results = 0;

  // zero length acts as one tick; anything past the timer range is clamped
  function automatic int fit_ticks(input int v);
    if (v == 0) v = 1;
    if (v > TIMER_MAX) v = TIMER_MAX;
    return v;
  endfunction

  function automatic int phase_ticks();
    int b;
    b = reg_bit_ticks;
    if (b == 0) b = 1;
    case (pred_phase)
      PH_PRE_HIGH: return fit_ticks(reg_pre_high);
      PH_PRE_LOW:  return fit_ticks(reg_pre_low);
      PH_DLM_LOW,
      PH_DLM_HIGH: return fit_ticks(reg_delim);
      PH_BIT:      return fit_ticks(b);
      PH_TRAIL:    return fit_ticks(b * 2);
      default:     return 1;
    endcase
  endfunction

  function automatic logic phase_level();
    case (pred_phase)
      PH_PRE_HIGH,
      PH_DLM_HIGH: return 1'b1;
      PH_BIT:      return (pred_bit_idx < ooktx_pkg::FRAME_LEN) ?
                          pred_frame[ooktx_pkg::FRAME_LEN - 1 - pred_bit_idx] : 1'b0;
      default:     return 1'b0;
    endcase
  endfunction

  // advance the predictor by one word and return the word it should produce
  task automatic predict_line(input logic req, input ooktx_pkg::in_word_t w,
                              output line_result_t r);
    logic [7:0] hdr;
    logic [7:0] trl;
    logic [7:0] pw;
    r = '0;
    if (req == REQ_SEND) begin
      if (pred_active) begin
        // send while a burst runs is dropped
        r.rej = 1'b1;
      end else begin
        hdr = (w.channel ? ooktx_pkg::HDR_CH_TWO : ooktx_pkg::HDR_CH_ONE)
            + (8'd1 << w.command);
        case (w.command)
          ooktx_pkg::CMD_SHOCK: trl = 8'h70;
          ooktx_pkg::CMD_BUZZ:  trl = 8'hB0;
          ooktx_pkg::CMD_BEEP:  trl = 8'hD0;
          default:              trl = 8'hE0;
        endcase
        if (!w.channel) trl = trl | ooktx_pkg::TRL_CH_ONE;
        pw = w.power % ooktx_pkg::PWR_MOD;
        pred_frame     = {hdr, w.id_high, w.id_low, pw, trl};
        pred_active    = 1'b1;
        pred_phase     = PH_PRE_HIGH;
        pred_timer     = '0;
        pred_bit_idx   = '0;
        pred_reps_left = (reg_repeat == 4'd0) ? 4'd1 : reg_repeat;
      end
    end else if (pred_active) begin
      r.line     = phase_level();
      pred_timer = pred_timer + 1'b1;
      if (pred_timer >= phase_ticks()) begin
        pred_timer = '0;
        case (pred_phase)
          PH_PRE_HIGH: pred_phase = PH_PRE_LOW;
          PH_PRE_LOW:  pred_phase = PH_DLM_LOW;
          PH_DLM_LOW:  pred_phase = PH_DLM_HIGH;
          PH_DLM_HIGH: pred_phase = (pred_bit_idx < ooktx_pkg::FRAME_LEN) ? PH_BIT : PH_TRAIL;
          PH_BIT: begin
            pred_bit_idx = pred_bit_idx + 1'b1;
            pred_phase   = PH_DLM_LOW;
          end
          PH_TRAIL: begin
            pred_reps_left = pred_reps_left - 1'b1;
            pred_bit_idx   = '0;
            if (pred_reps_left == 4'd0) begin
              pred_active = 1'b0;
              pred_phase  = PH_IDLE;
              r.done      = 1'b1;
            end else begin
              pred_phase = PH_PRE_HIGH;
            end
          end
          default: begin
            pred_active = 1'b0;
            pred_phase  = PH_IDLE;
          end
        endcase
      end
    end
    r.busy = pred_active;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on word %0d: %s got %0d want %0d", results, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge. The result check
  // runs before the prediction so a same-edge accept never matches itself.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    line_result_t want;
    line_result_t fresh;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word, tdata", out_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[0] !== want.line) report_mismatch("line_level", out_tdata[0], want.line);
          if (out_tdata[1] !== want.busy) report_mismatch("busy_res", out_tdata[1], want.busy);
          if (out_tdata[2] !== want.rej)  report_mismatch("rejected", out_tdata[2], want.rej);
          if (out_tlast !== want.done)    report_mismatch("burst_done", out_tlast, want.done);
          if (out_tdata[7:3] !== 5'd0)    report_mismatch("pad bits", out_tdata[7:3], 0);
        end
        results++;
      end
      if (in_tvalid && in_tready) begin
        predict_line(in_tuser, in_tdata[26:0], fresh);
        expected_q.push_back(fresh);
      end
    end
  end

  // watchdog: cycles in a row with neither side moving a word
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random ready at the falling edge, plus a long hold-off that
  // a test requests by bumping the ticket.
  // ---------------------------------------------------------------------
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int rx_hold_ticket = 0;
  int rx_hold_seen   = 0;
  int rx_hold_left   = 0;

  always @(negedge clk) begin
    if (rx_hold_ticket != rx_hold_seen) begin
      rx_hold_seen = rx_hold_ticket;
      rx_hold_left = RX_HOLD_LEN;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers. Every task starts and ends just after a falling edge.
  // ---------------------------------------------------------------------
  function automatic ooktx_pkg::in_word_t rand_word();
    ooktx_pkg::in_word_t w;
    w = ooktx_pkg::in_word_t'($urandom);
    return w;
  endfunction

  task automatic send_word(input logic req, input ooktx_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {5'd0, w};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // tick until the current burst has ended; tick payload is noise
  task automatic finish_burst();
    while (pred_active) send_word(REQ_TICK, rand_word());
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  // idle block only: drain, let the output stage settle, then write all five
  task automatic set_timing(input logic [15:0] bit_t, input logic [15:0] dlm_t,
                            input logic [15:0] pre_h, input logic [15:0] pre_l,
                            input logic [15:0] rep_word);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ooktx_pkg::REG_BIT_TICKS; cfg_wdata <= bit_t; reg_bit_ticks = bit_t;
    @(negedge clk);
    cfg_index <= ooktx_pkg::REG_DELIM;     cfg_wdata <= dlm_t; reg_delim = dlm_t;
    @(negedge clk);
    cfg_index <= ooktx_pkg::REG_PRE_HIGH;  cfg_wdata <= pre_h; reg_pre_high = pre_h;
    @(negedge clk);
    cfg_index <= ooktx_pkg::REG_PRE_LOW;   cfg_wdata <= pre_l; reg_pre_low = pre_l;
    @(negedge clk);
    cfg_index <= ooktx_pkg::REG_REPEAT;    cfg_wdata <= rep_word;
    reg_repeat = rep_word[3:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // zero included; it must act as one tick
  function automatic logic [15:0] rand_len(input int hi);
    return 16'($urandom_range(0, hi));
  endfunction

  task automatic set_random_timing();
    logic [15:0] rep_word;
    // junk in the upper bits; only the low nibble counts
    rep_word = {12'($urandom), 4'($urandom_range(0, 1))};
    set_timing(rand_len(1), rand_len(1), rand_len(6), rand_len(6), rep_word);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // ticks with no burst running: line low, not busy, no done
  task automatic test_idle_ticks();
    repeat (6) send_word(REQ_TICK, rand_word());
  endtask

  // all lengths zero (act as one tick), repeat nibble zero under junk upper
  // bits (acts as one); every command once, both channels, powers around the
  // modulo wrap; a send mid-burst; each later send right after burst_done
  task automatic test_frame_fields();
    ooktx_pkg::in_word_t w;
    set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFF0);
    for (int i = 0; i < 4; i++) begin
      w.channel = i[0] ^ i[1];
      w.command = i[1:0];
      w.power   = EDGE_POWER[i*8 +: 8];
      w.id_high = i[0] ? 8'hFF : 8'hA5;
      w.id_low  = i[1] ? 8'h00 : 8'h5A;
      send_word(REQ_SEND, w);
      if (i == 2) begin
        repeat (7) send_word(REQ_TICK, rand_word());
        send_word(REQ_SEND, ~w);  // rejected, frame must not change
      end
      finish_burst();
    end
  endtask

  // receiver holds off while ticks keep coming, so the block backs up;
  // later the sender stops until every word is back. Two packets per burst.
  task automatic test_backpressure();
    set_timing(16'd1, 16'd0, 16'd3, 16'd2, 16'd2);
    send_word(REQ_SEND, rand_word());
    repeat (20) send_word(REQ_TICK, rand_word());
    rx_hold_ticket++;
    repeat (60) send_word(REQ_TICK, rand_word());
    wait_drained();
    repeat (3) @(negedge clk);
    repeat (40) send_word(REQ_TICK, rand_word());
    wait_drained();
    finish_burst();
  endtask

  // mostly bursts with random frames; rejected sends and idle ticks as noise;
  // timing reprogrammed now and then between bursts
  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    int words;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    set_random_timing();
    words = 0;
    while (words < RANDOM_WORDS) begin
      if (!pred_active) begin
        if ($urandom_range(3) == 0) begin
          send_word(REQ_TICK, rand_word());
        end else begin
          if ($urandom_range(2) == 0) set_random_timing();
          send_word(REQ_SEND, rand_word());
        end
      end else if ($urandom_range(24) == 0) begin
        send_word(REQ_SEND, rand_word());
      end else begin
        send_word(REQ_TICK, rand_word());
      end
      words++;
    end
    finish_burst();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_idle_ticks();
    test_frame_fields();
    test_backpressure();
    test_random_traffic(34, 68);
    test_random_traffic(68, 34);
    test_random_traffic(0, 0);

    // let the last word out, then a few more edges for anything stray
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
